[design/vtp_pkg.sv]
package vtp_pkg;

    localparam int ENTRY_W   = 32;
    localparam int PROD_W    = 64;
    localparam int SW        = 66;
    localparam int MW        = 65;
    localparam int MAT_REGS  = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 4;
    localparam int DIV_STEPS = 33;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int ROWS      = 3;

    localparam logic [ENTRY_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [ENTRY_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [1:0] OP_PERSP = 2'd0;

    typedef struct packed {
        logic                          valid;
        logic                          persp;
        logic                          wz;
        logic                          clamp;
        logic [ROWS-1:0][ENTRY_W-1:0]  aff;
    } t_side;

endpackage

[design/vtp_row_sum.sv]
module vtp_row_sum
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic signed [ENTRY_W-1:0] i_x,
    input  logic signed [ENTRY_W-1:0] i_y,
    input  logic signed [ENTRY_W-1:0] i_z,
    input  logic signed [ENTRY_W-1:0] i_e0,
    input  logic signed [ENTRY_W-1:0] i_e1,
    input  logic signed [ENTRY_W-1:0] i_e2,
    input  logic signed [ENTRY_W-1:0] i_e3,
    input  logic                      i_with_t,
    output logic signed [SW-1:0]      o_sum
);

    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [SW-1:0]     r_t, r_a, r_b, r_sum;
    logic signed [PROD_W-1:0] n_p0, n_p1, n_p2;

    assign n_p0 = i_x * i_e0;
    assign n_p1 = i_y * i_e1;
    assign n_p2 = i_z * i_e2;

    always_ff @(posedge i_clk) begin
        r_p0  <= n_p0;
        r_p1  <= n_p1;
        r_p2  <= n_p2;
        r_t   <= i_with_t ? (SW'(i_e3) <<< FRAC_BITS) : '0;
        r_a   <= SW'(r_p0) + SW'(r_p1);
        r_b   <= SW'(r_p2) + r_t;
        r_sum <= r_a + r_b;
    end

    assign o_sum = r_sum;

endmodule

[design/vtp_div_pipe.sv]
module vtp_div_pipe
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic [MW+FRAC_BITS-1:0] i_num,
    input  logic [MW-1:0]      i_den,
    input  logic               i_neg,
    output logic [ENTRY_W-1:0] o_q,
    output logic               o_clamp
);

    localparam int NW = MW + FRAC_BITS;
    localparam int CW = (NW > MW + DIV_STEPS) ? NW : MW + DIV_STEPS;
    localparam int RW = MW + 1;

    logic [RW-1:0]        r_rem [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_low [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS+1];
    logic [MW-1:0]        r_den [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];
    logic [ENTRY_W-1:0]   r_out;
    logic                 r_clamp;

    logic [CW-1:0] n_num_ext, n_den_sh;

    assign n_num_ext = CW'(i_num);
    assign n_den_sh  = CW'({i_den, {DIV_STEPS{1'b0}}});

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'(i_num >> DIV_STEPS);
        r_low[0] <= i_num[DIV_STEPS-1:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        r_ovf[0] <= (n_num_ext >= n_den_sh);
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [RW-1:0] n_trial;
        logic          n_ge;

        assign n_trial = {r_rem[k][MW-1:0], r_low[k][DIV_STEPS-1]};
        assign n_ge    = (n_trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? (n_trial - {1'b0, r_den[k]}) : n_trial;
            r_low[k+1] <= {r_low[k][DIV_STEPS-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][DIV_STEPS-2:0], n_ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    logic [DIV_STEPS-1:0] n_qf;
    logic                 n_negf, n_ovff;
    logic [ENTRY_W-1:0]   n_out;
    logic                 n_clamp;

    assign n_qf   = r_q[DIV_STEPS];
    assign n_negf = r_neg[DIV_STEPS];
    assign n_ovff = r_ovf[DIV_STEPS];

    always_comb begin
        n_out   = n_qf[ENTRY_W-1:0];
        n_clamp = 1'b0;
        if (n_ovff) begin
            n_clamp = 1'b1;
            n_out   = n_negf ? SAT_MIN : SAT_MAX;
        end else if (n_negf) begin
            if (n_qf > DIV_STEPS'(SAT_MIN)) begin
                n_clamp = 1'b1;
                n_out   = SAT_MIN;
            end else begin
                n_out = -n_qf[ENTRY_W-1:0];
            end
        end else if (n_qf[DIV_STEPS-1] || n_qf[ENTRY_W-1]) begin
            n_clamp = 1'b1;
            n_out   = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_clamp <= n_clamp;
    end

    assign o_q     = r_out;
    assign o_clamp = r_clamp;

endmodule

[design/vertex_transform_perspective_top.sv]
// Transforms one point or direction per clock by the 4x4 Q16.16 matrix held in the
// configuration registers. A request is taken in every cycle (busy stays low), and its
// result appears on the outputs with o_done high after the row sums, the perspective
// divide and the output register; results are never held back, so the receiver must take
// each one in its cycle. The delay is set by the 33-step restoring divider; affine results
// follow in a matching side pipeline, so all leave in request order. Matrix writes
// take effect at once and should only be made while no request is in flight.
module vertex_transform_perspective_top
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_op,
    input  logic signed [ENTRY_W-1:0] i_in_x,
    input  logic signed [ENTRY_W-1:0] i_in_y,
    input  logic signed [ENTRY_W-1:0] i_in_z,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output logic                      o_done,
    output logic signed [ENTRY_W-1:0] o_out_x,
    output logic signed [ENTRY_W-1:0] o_out_y,
    output logic signed [ENTRY_W-1:0] o_out_z,
    output logic                      o_saturated,
    output logic                      o_w_was_zero
);

    localparam int NW = MW + FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0] r_mat [MAT_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAT_REGS; i++) begin
                r_mat[i] <= (i == 0 || i == 5) ? ONE :
                            (i == 2 || i == 7) ? (ONE << ENTRY_W) : '0;
            end
        end else if (i_cfg_we && !i_cfg_idx[CFG_IDX_W-1]) begin
            r_mat[i_cfg_idx[CFG_IDX_W-2:0]] <= i_cfg_data;
        end
    end

    logic signed [ENTRY_W-1:0] n_ent [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_ent[i] = (i % 2 == 1) ? r_mat[i/2][CFG_W-1:ENTRY_W] : r_mat[i/2][ENTRY_W-1:0];
        end
    end

    logic                 n_accept;
    logic signed [SW-1:0] n_sum [4];

    assign n_accept = start && !busy;
    assign busy     = 1'b0;

    for (genvar r = 0; r < 4; r++) begin : g_row
        vtp_row_sum #(
            .FRAC_BITS(FRAC_BITS)
        ) u_row (
            .i_clk   (i_clk),
            .i_x     (i_in_x),
            .i_y     (i_in_y),
            .i_z     (i_in_z),
            .i_e0    (n_ent[r]),
            .i_e1    (n_ent[r+4]),
            .i_e2    (n_ent[r+8]),
            .i_e3    (n_ent[r+12]),
            .i_with_t((r == 3) ? 1'b1 : !i_op[1]),
            .o_sum   (n_sum[r])
        );
    end

    logic [2:0] r_pv;
    logic [2:0] r_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[1:0], n_accept};
        end
        r_pop <= {r_pop[1:0], (i_op == OP_PERSP)};
    end

    logic                 n_wz, n_wn;
    logic signed [SW-1:0] n_wf, n_sa;
    logic [MW-1:0]        n_den;
    logic [NW-1:0]        n_num [ROWS];
    logic                 n_neg [ROWS];
    t_side                n_side;

    always_comb begin
        n_wz  = (n_sum[3] == '0);
        n_wf  = n_wz ? (SW'(1) <<< (2 * FRAC_BITS)) : n_sum[3];
        n_wn  = n_wf[SW-1];
        n_den = n_wn ? MW'(-n_wf) : MW'(n_wf);
        n_side.valid = r_pv[2];
        n_side.persp = r_pop[2];
        n_side.wz    = r_pop[2] && n_wz;
        n_side.clamp = 1'b0;
        n_side.aff   = '0;
        n_sa         = '0;
        for (int r = 0; r < ROWS; r++) begin
            n_num[r] = {(n_sum[r][SW-1] ? MW'(-n_sum[r]) : MW'(n_sum[r])), {FRAC_BITS{1'b0}}};
            n_neg[r] = n_sum[r][SW-1] ^ n_wn;
            n_sa     = n_sum[r] >>> FRAC_BITS;
            if (n_sa[SW-1:ENTRY_W-1] != '0 && n_sa[SW-1:ENTRY_W-1] != '1) begin
                n_side.clamp  = 1'b1;
                n_side.aff[r] = n_sa[SW-1] ? SAT_MIN : SAT_MAX;
            end else begin
                n_side.aff[r] = n_sa[ENTRY_W-1:0];
            end
        end
    end

    logic [NW-1:0] r_num [ROWS];
    logic [MW-1:0] r_den;
    logic          r_neg [ROWS];
    t_side         r_side [DIV_LAT+1];

    always_ff @(posedge i_clk) begin
        r_den <= n_den;
        for (int r = 0; r < ROWS; r++) begin
            r_num[r] <= n_num[r];
            r_neg[r] <= n_neg[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_LAT; i++) begin
                r_side[i] <= '0;
            end
        end else begin
            r_side[0] <= n_side;
            for (int i = 1; i <= DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    logic [ENTRY_W-1:0] n_q [ROWS];
    logic [ROWS-1:0]    n_dclamp;

    for (genvar r = 0; r < ROWS; r++) begin : g_div
        vtp_div_pipe #(
            .FRAC_BITS(FRAC_BITS)
        ) u_div (
            .i_clk  (i_clk),
            .i_num  (r_num[r]),
            .i_den  (r_den),
            .i_neg  (r_neg[r]),
            .o_q    (n_q[r]),
            .o_clamp(n_dclamp[r])
        );
    end

    t_side                     n_fin;
    logic                      r_done, r_sat, r_wz;
    logic signed [ENTRY_W-1:0] r_x, r_y, r_z;

    assign n_fin = r_side[DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_sat  <= 1'b0;
            r_wz   <= 1'b0;
        end else begin
            r_done <= n_fin.valid;
            r_wz   <= n_fin.valid && n_fin.wz;
            r_sat  <= n_fin.valid && (n_fin.persp ? (|n_dclamp) : n_fin.clamp);
        end
        r_x <= n_fin.persp ? n_q[0] : n_fin.aff[0];
        r_y <= n_fin.persp ? n_q[1] : n_fin.aff[1];
        r_z <= n_fin.persp ? n_q[2] : n_fin.aff[2];
    end

    assign o_done       = r_done;
    assign o_saturated  = r_sat;
    assign o_w_was_zero = r_wz;
    assign o_out_x      = r_x;
    assign o_out_y      = r_y;
    assign o_out_z      = r_z;

    a_flags_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_saturated || o_w_was_zero) |-> o_done)
        else $error("result flags raised without a result");

    a_sat_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> (o_out_x == SAT_MAX || o_out_x == SAT_MIN ||
                         o_out_y == SAT_MAX || o_out_y == SAT_MIN ||
                         o_out_z == SAT_MAX || o_out_z == SAT_MIN))
        else $error("saturation flagged but no coordinate at a rail");

    a_wz_persp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_fin.wz |-> n_fin.persp)
        else $error("zero w flagged outside the perspective op");

endmodule
